// ===== hw/rtl/cdsb_pkg.sv =====
// ----------------------------------------------------------------------------
// cdsb_pkg
// Shared constants and types for the time-of-day clock with debounced
// set buttons: register indexes, time limits, reset values, press flags.
// ----------------------------------------------------------------------------
package cdsb_pkg;

	localparam int NUM_BUTTONS = 3;

	// Configuration register indexes
	localparam logic [2:0] CFG_DEBOUNCE_TICKS    = 3'd0;
	localparam logic [2:0] CFG_TICKS_PER_SECOND  = 3'd1;
	localparam logic [2:0] CFG_BRIGHT_LEVEL_ZERO = 3'd2;
	localparam logic [2:0] CFG_BRIGHT_LEVEL_ONE  = 3'd3;
	localparam logic [2:0] CFG_BRIGHT_LEVEL_TWO  = 3'd4;
	localparam logic [2:0] CFG_BRIGHT_LEVEL_THREE = 3'd5;

	// Time limits
	localparam logic [5:0] SECS_PER_MIN  = 6'd60;
	localparam logic [5:0] MINS_PER_HOUR = 6'd60;
	localparam logic [4:0] HOURS_PER_DAY = 5'd24;

	// Configuration reset values
	localparam logic [7:0]  RST_DEBOUNCE_TICKS   = 8'd4;
	localparam logic [15:0] RST_TICKS_PER_SECOND = 16'd16;
	localparam logic [7:0]  RST_BRIGHT_ZERO      = 8'd32;
	localparam logic [7:0]  RST_BRIGHT_ONE       = 8'd96;
	localparam logic [7:0]  RST_BRIGHT_TWO       = 8'd160;
	localparam logic [7:0]  RST_BRIGHT_THREE     = 8'd255;

	// Debounced presses accepted on one tick
	typedef struct packed {
		logic bright_press;
		logic hour_press;
		logic min_press;
	} press_t;

endpackage

// ===== hw/rtl/cdsb_debounce.sv =====
// ----------------------------------------------------------------------------
// cdsb_debounce
// One button debouncer: counts ticks of an unchanged raw level and moves it
// to the stable level once the count reaches the threshold.
// ----------------------------------------------------------------------------
module cdsb_debounce (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       raw,
	input  logic [7:0] debounce_ticks,
	output logic       press
);

	logic       prev_q;
	logic       stable_q;
	logic [7:0] settle_q;
	logic [7:0] settle_nx;
	logic       fire;

	// Clear on a level change, otherwise count up to the threshold
	always_comb begin
		if (raw != prev_q) begin
			settle_nx = 8'd0;
		end else if (settle_q < debounce_ticks) begin
			settle_nx = settle_q + 8'd1;
		end else begin
			settle_nx = settle_q;
		end
	end

	assign fire  = (settle_nx >= debounce_ticks) && (raw != stable_q);
	assign press = en && fire && !raw;

	// Hold state between ticks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= 1'b1;
			stable_q <= 1'b1;
			settle_q <= 8'd0;
		end else if (en) begin
			prev_q   <= raw;
			settle_q <= settle_nx;
			if (fire) begin
				stable_q <= raw;
			end
		end
	end

endmodule

// ===== hw/rtl/cdsb_timekeep.sv =====
// ----------------------------------------------------------------------------
// cdsb_timekeep
// Time and brightness state: applies button presses, the tick prescaler,
// the minute-hold step and rollovers, and presents the next state.
// ----------------------------------------------------------------------------
module cdsb_timekeep (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic           mode,
	input  logic           min_raw,
	input  cdsb_pkg::press_t press,
	input  logic [15:0]    ticks_per_second,
	output logic [5:0]     sec_nx,
	output logic [5:0]     min_nx,
	output logic [4:0]     hour_nx,
	output logic [1:0]     stage_nx,
	output logic           refresh_nx
);

	logic [15:0] tick_q;
	logic [5:0]  sec_q;
	logic [5:0]  min_q;
	logic [4:0]  hour_q;
	logic [1:0]  stage_q;
	logic        hold_q;

	logic [15:0] tick_nx;
	logic        hold_nx;
	logic [16:0] tick_inc;

	// Work out the state after this item
	always_comb begin
		tick_inc   = {1'b0, tick_q} + 17'd1;
		tick_nx    = tick_q;
		sec_nx     = sec_q;
		min_nx     = min_q;
		hour_nx    = hour_q;
		stage_nx   = stage_q;
		hold_nx    = hold_q;
		refresh_nx = 1'b0;
		if (mode) begin
			// Pin change: arm or drop the minute hold
			hold_nx = !min_raw;
		end else begin
			if (press.min_press && !hold_q) begin
				sec_nx     = 6'd0;
				refresh_nx = 1'b1;
				if (min_nx == cdsb_pkg::MINS_PER_HOUR - 6'd1) begin
					min_nx  = 6'd0;
					hour_nx = (hour_nx == cdsb_pkg::HOURS_PER_DAY - 5'd1) ?
						5'd0 : hour_nx + 5'd1;
				end else begin
					min_nx = min_nx + 6'd1;
				end
			end
			if (press.hour_press) begin
				refresh_nx = 1'b1;
				hour_nx    = (hour_nx == cdsb_pkg::HOURS_PER_DAY - 5'd1) ?
					5'd0 : hour_nx + 5'd1;
			end
			if (press.bright_press) begin
				stage_nx = stage_nx + 2'd1;
			end
			// Second boundary
			if (tick_inc >= {1'b0, ticks_per_second}) begin
				tick_nx    = 16'd0;
				refresh_nx = 1'b1;
				if (hold_q) begin
					sec_nx  = 6'd0;
					hold_nx = 1'b0;
					min_nx  = (min_nx == 6'd0) ?
						cdsb_pkg::MINS_PER_HOUR - 6'd1 : min_nx - 6'd1;
				end else if (sec_nx == cdsb_pkg::SECS_PER_MIN - 6'd1) begin
					sec_nx = 6'd0;
					if (min_nx == cdsb_pkg::MINS_PER_HOUR - 6'd1) begin
						min_nx  = 6'd0;
						hour_nx = (hour_nx == cdsb_pkg::HOURS_PER_DAY - 5'd1) ?
							5'd0 : hour_nx + 5'd1;
					end else begin
						min_nx = min_nx + 6'd1;
					end
				end else begin
					sec_nx = sec_nx + 6'd1;
				end
			end else begin
				tick_nx = tick_inc[15:0];
			end
		end
	end

	// Commit state when the item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= 16'd0;
			sec_q   <= 6'd0;
			min_q   <= 6'd0;
			hour_q  <= 5'd0;
			stage_q <= 2'd0;
			hold_q  <= 1'b0;
		end else if (advance) begin
			tick_q  <= tick_nx;
			sec_q   <= sec_nx;
			min_q   <= min_nx;
			hour_q  <= hour_nx;
			stage_q <= stage_nx;
			hold_q  <= hold_nx;
		end
	end

endmodule

// ===== hw/rtl/clock_with_debounced_set_buttons.sv =====
// ----------------------------------------------------------------------------
// clock_with_debounced_set_buttons
// Time-of-day clock driven by tick and minute-pin events, with three
// debounced set buttons and a four-stage brightness selection.
// ----------------------------------------------------------------------------
// Path: an item is held in the input register until the result slot frees up,
//   then loads into the result register.
// Throughput: one item per cycle while the result stream is not stalled; the
//   time state updates in a single pass between the input and result registers.
// Reset: arst_n clears the clock to 00:00:00, stage 0, buttons released,
//   configuration to its defaults; no clearing pass is needed.
module clock_with_debounced_set_buttons (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // min_level, hour_level, bright_level, zero pad
	input  logic        s_axis_tuser,  // mode
	// Result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // out_seconds, out_minutes, out_hours, out_stage,
	                                   // pwm_compare, display_refresh, zero pad
	// Configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	logic [7:0]  debounce_ticks_q;
	logic [15:0] ticks_per_second_q;
	logic [7:0]  bright_q [4];

	logic        in_valid_s1;
	logic        mode_s1;
	logic [2:0]  raw_s1;
	logic        out_valid_s2;
	logic [31:0] result_s2;

	logic        advance;
	logic        tick_en;
	cdsb_pkg::press_t press;
	logic [5:0]  sec_nx;
	logic [5:0]  min_nx;
	logic [4:0]  hour_nx;
	logic [1:0]  stage_nx;
	logic        refresh_nx;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q   <= cdsb_pkg::RST_DEBOUNCE_TICKS;
			ticks_per_second_q <= cdsb_pkg::RST_TICKS_PER_SECOND;
			bright_q[0]        <= cdsb_pkg::RST_BRIGHT_ZERO;
			bright_q[1]        <= cdsb_pkg::RST_BRIGHT_ONE;
			bright_q[2]        <= cdsb_pkg::RST_BRIGHT_TWO;
			bright_q[3]        <= cdsb_pkg::RST_BRIGHT_THREE;
		end else if (cfg_we) begin
			case (cfg_index)
				cdsb_pkg::CFG_DEBOUNCE_TICKS:     debounce_ticks_q   <= cfg_wdata[7:0];
				cdsb_pkg::CFG_TICKS_PER_SECOND:   ticks_per_second_q <= cfg_wdata;
				cdsb_pkg::CFG_BRIGHT_LEVEL_ZERO:  bright_q[0]        <= cfg_wdata[7:0];
				cdsb_pkg::CFG_BRIGHT_LEVEL_ONE:   bright_q[1]        <= cfg_wdata[7:0];
				cdsb_pkg::CFG_BRIGHT_LEVEL_TWO:   bright_q[2]        <= cfg_wdata[7:0];
				cdsb_pkg::CFG_BRIGHT_LEVEL_THREE: bright_q[3]        <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// Handshake: move the held item on when the result slot frees up
	assign advance       = in_valid_s1 && (!out_valid_s2 || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || advance;
	assign tick_en       = advance && !mode_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			mode_s1 <= s_axis_tuser;
			raw_s1  <= s_axis_tdata[2:0];
		end
	end

	// Button debouncers
	cdsb_debounce u_db_min (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (tick_en),
		.raw            (raw_s1[0]),
		.debounce_ticks (debounce_ticks_q),
		.press          (press.min_press)
	);

	cdsb_debounce u_db_hour (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (tick_en),
		.raw            (raw_s1[1]),
		.debounce_ticks (debounce_ticks_q),
		.press          (press.hour_press)
	);

	cdsb_debounce u_db_bright (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (tick_en),
		.raw            (raw_s1[2]),
		.debounce_ticks (debounce_ticks_q),
		.press          (press.bright_press)
	);

	// Time and brightness state
	cdsb_timekeep u_timekeep (
		.clk              (clk),
		.arst_n           (arst_n),
		.advance          (advance),
		.mode             (mode_s1),
		.min_raw          (raw_s1[0]),
		.press            (press),
		.ticks_per_second (ticks_per_second_q),
		.sec_nx           (sec_nx),
		.min_nx           (min_nx),
		.hour_nx          (hour_nx),
		.stage_nx         (stage_nx),
		.refresh_nx       (refresh_nx)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= {4'd0, refresh_nx, bright_q[stage_nx], stage_nx,
				hour_nx, min_nx, sec_nx};
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = result_s2;

`ifndef SYNTHESIS
	// Time fields stay in range on every shown result
	a_sec_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 |-> (result_s2[5:0] < cdsb_pkg::SECS_PER_MIN))
		else $error("seconds out of range");

	a_min_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 |-> (result_s2[11:6] < cdsb_pkg::MINS_PER_HOUR))
		else $error("minutes out of range");

	a_hour_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 |-> (result_s2[16:12] < cdsb_pkg::HOURS_PER_DAY))
		else $error("hours out of range");

	// A pin-change event never asks for a display update
	a_event_no_refresh: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && mode_s1) |=> (out_valid_s2 && !result_s2[27]))
		else $error("refresh raised by pin-change event");

	// Input stalls only while an item is held
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (in_valid_s1 && out_valid_s2))
		else $error("input stalled with free slots");
`endif

endmodule
